@@ hw/rtl/tatc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tatc_pkg;

    // converter and field widths
    localparam int ADC_BITS   = 10;
    localparam int SAMPLE_W   = 10;
    localparam int RES_W      = 20;
    localparam int COEF_W     = 48;
    localparam int TEMP_W     = 16;
    localparam int RES_OUT_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;

    // internal widths
    localparam int NUM_W      = RES_W + ADC_BITS;
    localparam int PN_W       = $clog2(NUM_W);
    localparam int PD_W       = $clog2(ADC_BITS);
    localparam int MANT_W     = 32;
    localparam int FRAC_W     = 32;
    localparam int QUO_W      = 32;
    localparam int LN_W       = 38;
    localparam int L_W        = LN_W + 1;
    localparam int W64        = 64;
    localparam int MAG_W      = 48;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int KQ_W       = 16;
    localparam int KREM_W     = 64;
    localparam int KDIV_W     = KREM_W + KQ_W - 1;
    localparam int N_CELLS    = FRAC_W;

    // constants
    localparam logic [FRAC_W-1:0]   LN2_Q32    = 32'd2977044472;
    localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
    localparam logic [KREM_W-1:0]   CENTI_ONE  = 64'd100 << 48;
    localparam int                  KELVIN_OFS = 27315;
    localparam int                  TEMP_MAX   = 32767;
    localparam int                  KQ_LIMIT   = TEMP_MAX + KELVIN_OFS;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIXED_RES = 3'd0,
        REG_COEF_A    = 3'd1,
        REG_COEF_B    = 3'd2,
        REG_COEF_C    = 3'd3
    } t_reg_idx;

    // payload of one log / divide cell
    typedef struct packed {
        t_status             status;
        logic [PN_W-1:0]     pn;
        logic [PD_W-1:0]     pd;
        logic [MANT_W-1:0]   mn;
        logic [MANT_W-1:0]   md;
        logic [FRAC_W-1:0]   fn;
        logic [FRAC_W-1:0]   fd;
        logic [ADC_BITS-1:0] rem;
        logic [ADC_BITS-1:0] den;
        logic [QUO_W-1:0]    dq;
    } t_cell;

    // status and resistance riding along the back half
    typedef struct packed {
        t_status          status;
        logic [QUO_W-1:0] q;
    } t_side;

    // payload of one kelvin divide cell
    typedef struct packed {
        t_status           status;
        logic [QUO_W-1:0]  q;
        logic              ovf;
        logic [KREM_W-1:0] rem;
        logic [KDIV_W-1:0] dsh;
        logic [KQ_W-1:0]   kq;
    } t_kdiv;

    // index of the highest set bit, zero for zero
    function automatic logic [PN_W-1:0] msb_num(input logic [NUM_W-1:0] x);
        logic [PN_W-1:0] p;
        p = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (x[i]) p = PN_W'(i);
        end
        return p;
    endfunction

    function automatic logic [PD_W-1:0] msb_den(input logic [ADC_BITS-1:0] x);
        logic [PD_W-1:0] p;
        p = '0;
        for (int i = 0; i < ADC_BITS; i++) begin
            if (x[i]) p = PD_W'(i);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/thermistor_adc_to_temperature.sv @@
// throughput: one sample per cycle while the pipeline is not held;
// 32 log/divide cells and 16 kelvin divide cells each hold one item, and four
// 3-stage multipliers form the Steinhart-Hart sum
// the whole pipeline holds only while the output item waits and a new one is ready
// reset (synchronous, active low) empties the pipeline and clears the configuration to 0
`timescale 1ns / 1ps
`default_nettype none

module thermistor_adc_to_temperature (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [tatc_pkg::SAMPLE_W-1:0]          i_adc_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [tatc_pkg::TEMP_W-1:0]     o_temperature_centi,
    output logic [tatc_pkg::RES_OUT_W-1:0]         o_resistance_ohms,
    output logic [tatc_pkg::STATUS_W-1:0]          o_status,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tatc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tatc_pkg::COEF_W-1:0]            i_cfg_data
);
    import tatc_pkg::*;

    logic                      adv;
    logic                      load;

    logic [RES_W-1:0]          r_fixed_res;
    logic signed [COEF_W-1:0]  r_coef_a;
    logic signed [COEF_W-1:0]  r_coef_b;
    logic signed [COEF_W-1:0]  r_coef_c;

    logic [ADC_BITS-1:0]       smp;
    t_status                   n_s0_status;
    logic                      r_s0v;
    logic [NUM_W-1:0]          r_s0_num;
    logic [ADC_BITS-1:0]       r_s0_den;
    t_status                   r_s0_status;

    logic [PN_W-1:0]           pn;
    logic [PD_W-1:0]           pd;
    t_cell                     n_s1;
    logic                      r_s1v;
    t_cell                     r_s1;

    logic                      c_v [0:N_CELLS];
    t_cell                     c_d [0:N_CELLS];
    t_cell                     c_last;

    logic [W64-1:0]            fprod_n;
    logic [W64-1:0]            fprod_d;
    logic                      r_l1v;
    logic [LN_W-1:0]           r_ln_n;
    logic [LN_W-1:0]           r_ln_d;
    t_side                     r_l1_side;

    logic                      r_l2v;
    logic signed [L_W-1:0]     r_l;
    t_side                     r_l2_side;

    logic signed [W64-1:0]     l64;
    logic signed [W64-1:0]     l2p;
    logic signed [W64-1:0]     blp;
    logic signed [W64-1:0]     l3p;
    logic signed [W64-1:0]     cl3p;
    logic signed [W64-1:0]     r_ld [1:3];
    logic signed [W64-1:0]     r_bd [1:6];
    logic                      r_pv [1:10];
    t_side                     r_sd [1:10];
    logic signed [W64-1:0]     r_sum;

    logic [KREM_W-1:0]         kd_num;
    t_kdiv                     n_kd0;
    logic                      r_kd0v;
    t_kdiv                     r_kd0;
    logic                      k_v [0:KQ_W];
    t_kdiv                     k_d [0:KQ_W];
    t_kdiv                     k_last;

    logic [TEMP_W-1:0]         n_temp;
    logic [RES_OUT_W-1:0]      n_res;
    logic                      r_ovld;
    logic [TEMP_W-1:0]         r_otemp;
    logic [RES_OUT_W-1:0]      r_ores;
    t_status                   r_ostatus;

    // flow control: hold only when the output item waits and another is ready
    assign k_last  = k_d[KQ_W];
    assign adv     = !(k_v[KQ_W] && r_ovld && i_stall);
    assign load    = adv && k_v[KQ_W];
    assign o_stall = !adv;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_res <= '0;
            r_coef_a    <= '0;
            r_coef_b    <= '0;
            r_coef_c    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIXED_RES: r_fixed_res <= i_cfg_data[RES_W-1:0];
                REG_COEF_A:    r_coef_a    <= signed'(i_cfg_data);
                REG_COEF_B:    r_coef_b    <= signed'(i_cfg_data);
                REG_COEF_C:    r_coef_c    <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // stage 0: divider numerator, denominator and special cases
    assign smp = i_adc_sample[ADC_BITS-1:0];

    always_comb begin
        if (smp == FULL_SCALE) begin
            n_s0_status = ST_FULL;
        end else if (smp == '0) begin
            n_s0_status = ST_ZERO;
        end else if (r_fixed_res == '0) begin
            n_s0_status = ST_BAD;
        end else begin
            n_s0_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0v <= 1'b0;
        end else if (adv) begin
            r_s0v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_num    <= NUM_W'(r_fixed_res) * NUM_W'(smp);
            r_s0_den    <= FULL_SCALE - smp;
            r_s0_status <= n_s0_status;
        end
    end

    // stage 1: normalize both log arguments to q1.31 mantissas
    always_comb begin
        pn          = msb_num(r_s0_num);
        pd          = msb_den(r_s0_den);
        n_s1.status = r_s0_status;
        n_s1.pn     = pn;
        n_s1.pd     = pd;
        n_s1.mn     = MANT_W'(r_s0_num) << (PN_W'(MANT_W - 1) - pn);
        n_s1.md     = MANT_W'(r_s0_den) << (PN_W'(MANT_W - 1) - PN_W'(pd));
        n_s1.fn     = '0;
        n_s1.fd     = '0;
        n_s1.rem    = '0;
        n_s1.den    = r_s0_den;
        n_s1.dq     = QUO_W'(r_s0_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (adv) begin
            r_s1v <= r_s0v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_s1 <= n_s1;
    end

    // chain of log-fraction and resistance-divide cells
    assign c_v[0] = r_s1v;
    assign c_d[0] = r_s1;

    for (genvar gi = 0; gi < N_CELLS; gi++) begin : g_cell
        tatc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_vld   (c_v[gi]),
            .i_d     (c_d[gi]),
            .o_vld   (c_v[gi+1]),
            .o_d     (c_d[gi+1])
        );
    end

    assign c_last = c_d[N_CELLS];

    // natural logs in q32
    assign fprod_n = W64'(c_last.fn) * W64'(LN2_Q32);
    assign fprod_d = W64'(c_last.fd) * W64'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1v <= 1'b0;
            r_l2v <= 1'b0;
        end else if (adv) begin
            r_l1v <= c_v[N_CELLS];
            r_l2v <= r_l1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ln_n <= LN_W'(LN_W'(c_last.pn) * LN_W'(LN2_Q32))
                    + LN_W'(fprod_n[W64-1:FRAC_W]);
            r_ln_d <= LN_W'(LN_W'(c_last.pd) * LN_W'(LN2_Q32))
                    + LN_W'(fprod_d[W64-1:FRAC_W]);
            r_l1_side.status <= c_last.status;
            r_l1_side.q      <= c_last.dq;
            r_l         <= signed'({1'b0, r_ln_n}) - signed'({1'b0, r_ln_d});
            r_l2_side   <= r_l1_side;
        end
    end

    // polynomial: l^2, b*l, l^3, c*l^3
    assign l64 = W64'(r_l);

    tatc_mul u_mul_l2 (
        .i_clk (i_clk), .i_en (adv), .i_a (l64), .i_b (l64), .o_p (l2p)
    );

    tatc_mul u_mul_bl (
        .i_clk (i_clk), .i_en (adv), .i_a (W64'(r_coef_b)), .i_b (l64), .o_p (blp)
    );

    tatc_mul u_mul_l3 (
        .i_clk (i_clk), .i_en (adv), .i_a (l2p), .i_b (r_ld[3]), .o_p (l3p)
    );

    tatc_mul u_mul_cl3 (
        .i_clk (i_clk), .i_en (adv), .i_a (W64'(r_coef_c)), .i_b (l3p), .o_p (cl3p)
    );

    // delay lines that line operands and side data up with the multipliers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ld[1] <= l64;
            for (int i = 2; i <= 3; i++) r_ld[i] <= r_ld[i-1];
            r_bd[1] <= blp;
            for (int i = 2; i <= 6; i++) r_bd[i] <= r_bd[i-1];
            r_sd[1] <= r_l2_side;
            for (int i = 2; i <= 10; i++) r_sd[i] <= r_sd[i-1];
            r_sum <= W64'(r_coef_a) + r_bd[6] + cl3p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 10; i++) r_pv[i] <= 1'b0;
        end else if (adv) begin
            r_pv[1] <= r_l2v;
            for (int i = 2; i <= 10; i++) r_pv[i] <= r_pv[i-1];
        end
    end

    // kelvin divide setup: rounded dividend, overflow check, bad sum
    always_comb begin
        kd_num       = CENTI_ONE + (unsigned'(r_sum) >> 1);
        n_kd0.q      = r_sd[10].q;
        n_kd0.status = (r_sd[10].status == ST_OK && (r_sum[W64-1] || r_sum == '0))
                     ? ST_BAD : r_sd[10].status;
        n_kd0.rem    = kd_num;
        n_kd0.dsh    = KDIV_W'(unsigned'(r_sum)) << (KQ_W - 1);
        n_kd0.ovf    = KDIV_W'(kd_num) >= (KDIV_W'(unsigned'(r_sum)) << KQ_W);
        n_kd0.kq     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kd0v <= 1'b0;
        end else if (adv) begin
            r_kd0v <= r_pv[10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_kd0 <= n_kd0;
    end

    assign k_v[0] = r_kd0v;
    assign k_d[0] = r_kd0;

    for (genvar gk = 0; gk < KQ_W; gk++) begin : g_kdiv
        tatc_kdiv_cell u_kdiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_vld   (k_v[gk]),
            .i_d     (k_d[gk]),
            .o_vld   (k_v[gk+1]),
            .o_d     (k_d[gk+1])
        );
    end

    // result fields with saturation and special cases
    always_comb begin
        if (k_last.status != ST_OK) begin
            n_temp = '0;
        end else if (k_last.ovf || k_last.kq > KQ_W'(KQ_LIMIT)) begin
            n_temp = TEMP_W'(TEMP_MAX);
        end else begin
            n_temp = TEMP_W'(k_last.kq - KQ_W'(KELVIN_OFS));
        end
        n_res = (k_last.status == ST_FULL) ? '1 : k_last.q;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load) begin
            r_ovld <= 1'b1;
        end else if (!i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_otemp   <= n_temp;
            r_ores    <= n_res;
            r_ostatus <= k_last.status;
        end
    end

    assign o_valid             = r_ovld;
    assign o_temperature_centi = signed'(r_otemp);
    assign o_resistance_ohms   = r_ores;
    assign o_status            = r_ostatus;

    // checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_ovld && i_stall && k_v[KQ_W]))
        else $error("pipeline held without a waiting output item");

    a_flag_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_temperature_centi == '0))
        else $error("flagged item carries a temperature");

    a_full_scale_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_resistance_ohms == '1))
        else $error("full-scale item without saturated resistance");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !k_v[KQ_W]) |=> !o_valid)
        else $error("output item appeared from an empty pipeline");

    a_temp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_temperature_centi >= -KELVIN_OFS))
        else $error("temperature below absolute zero");

endmodule

`default_nettype wire

@@ hw/rtl/tatc_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tatc_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [tatc_pkg::W64-1:0]   i_a,
    input  logic signed [tatc_pkg::W64-1:0]   i_b,
    output logic signed [tatc_pkg::W64-1:0]   o_p
);
    import tatc_pkg::*;

    logic [W64-1:0]      abs_a;
    logic [W64-1:0]      abs_b;
    logic                r_neg1;
    logic [MAG_W-1:0]    r_ma;
    logic [MAG_W-1:0]    r_mb;
    logic                r_neg2;
    logic [MAG_W-1:0]    r_p00;
    logic [MAG_W-1:0]    r_p01;
    logic [MAG_W-1:0]    r_p10;
    logic [MAG_W-1:0]    r_p11;
    logic [PROD_W-1:0]   full;
    logic [W64-2:0]      mag;
    logic [W64-1:0]      n_p;
    logic [W64-1:0]      r_p;

    // sign and magnitude split
    assign abs_a = i_a[W64-1] ? W64'(-i_a) : W64'(i_a);
    assign abs_b = i_b[W64-1] ? W64'(-i_b) : W64'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[W64-1] ^ i_b[W64-1];
            r_ma   <= abs_a[MAG_W-1:0];
            r_mb   <= abs_b[MAG_W-1:0];
        end
    end

    // half-word partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_neg1;
            r_p00  <= r_ma[HALF_W-1:0]     * r_mb[HALF_W-1:0];
            r_p01  <= r_ma[HALF_W-1:0]     * r_mb[MAG_W-1:HALF_W];
            r_p10  <= r_ma[MAG_W-1:HALF_W] * r_mb[HALF_W-1:0];
            r_p11  <= r_ma[MAG_W-1:HALF_W] * r_mb[MAG_W-1:HALF_W];
        end
    end

    // sum, drop 32 fraction bits of the magnitude, restore sign
    always_comb begin
        full = PROD_W'(r_p00) + (PROD_W'(r_p01) << HALF_W)
             + (PROD_W'(r_p10) << HALF_W) + (PROD_W'(r_p11) << MAG_W);
        mag  = full[PROD_W-2:FRAC_W];
        n_p  = r_neg2 ? W64'(-{1'b0, mag}) : {1'b0, mag};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_p <= n_p;
    end

    assign o_p = signed'(r_p);

endmodule

`default_nettype wire

@@ hw/rtl/tatc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tatc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  tatc_pkg::t_cell i_d,
    output logic            o_vld,
    output tatc_pkg::t_cell o_d
);
    import tatc_pkg::*;

    logic [2*MANT_W-1:0] sq_n;
    logic [2*MANT_W-1:0] sq_d;
    logic [MANT_W:0]     tn;
    logic [MANT_W:0]     td;
    logic [ADC_BITS:0]   trial;
    logic                ge;
    logic                r_vld;
    t_cell               r_d;
    t_cell               n_d;

    always_comb begin
        n_d = i_d;

        // one squaring step of each log mantissa
        sq_n = (2*MANT_W)'(i_d.mn) * (2*MANT_W)'(i_d.mn);
        sq_d = (2*MANT_W)'(i_d.md) * (2*MANT_W)'(i_d.md);
        tn   = sq_n[2*MANT_W-1:MANT_W-1];
        td   = sq_d[2*MANT_W-1:MANT_W-1];
        n_d.mn = tn[MANT_W] ? tn[MANT_W:1] : tn[MANT_W-1:0];
        n_d.md = td[MANT_W] ? td[MANT_W:1] : td[MANT_W-1:0];
        n_d.fn = {i_d.fn[FRAC_W-2:0], tn[MANT_W]};
        n_d.fd = {i_d.fd[FRAC_W-2:0], td[MANT_W]};

        // one restoring step of the resistance divide
        trial = {i_d.rem, i_d.dq[QUO_W-1]};
        ge    = trial >= {1'b0, i_d.den};
        n_d.rem = ge ? ADC_BITS'(trial - {1'b0, i_d.den}) : trial[ADC_BITS-1:0];
        n_d.dq  = {i_d.dq[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

@@ hw/rtl/tatc_kdiv_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tatc_kdiv_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  tatc_pkg::t_kdiv  i_d,
    output logic             o_vld,
    output tatc_pkg::t_kdiv  o_d
);
    import tatc_pkg::*;

    logic [KDIV_W-1:0] rem_x;
    logic              ge;
    logic              r_vld;
    t_kdiv             r_d;
    t_kdiv             n_d;

    // one quotient bit: compare against the shifted divisor
    always_comb begin
        n_d    = i_d;
        rem_x  = KDIV_W'(i_d.rem);
        ge     = rem_x >= i_d.dsh;
        n_d.rem = ge ? KREM_W'(rem_x - i_d.dsh) : i_d.rem;
        n_d.kq  = {i_d.kq[KQ_W-2:0], ge};
        n_d.dsh = i_d.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire
